// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is active
`define ILS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define ILS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/ils_pkg.sv -----
// types, command and status codes for the indexed list store
`default_nettype none

package ils_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned POS_W        = 12;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned ST_W         = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_IDX  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_IDX  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  localparam logic signed [VAL_W-1:0] VAL_NOT_FOUND = -32'sd1;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value_in;
  } ils_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [ST_W-1:0]         status;
  } ils_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/indexed_list_store_core.sv -----
// indexed list store: ordered value list in a single-port-pair memory with a shift sequencer
// get: busy in S_GET; result strobed from done_q after the registered memory read
// rejected requests and unused commands: not busy, result strobed the next cycle
// insert/delete moving n elements: busy in S_SHIFT until the moves and the final step are done;
// n <= CAPACITY - 1; the memory moves one element per cycle through its write port
// async active-low reset empties the list; memory contents are not cleared
`default_nettype none

module indexed_list_store_core #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire ils_pkg::ils_req_t req_i,
  output logic                   busy,
  output logic                   result_valid_o,
  output ils_pkg::ils_rsp_t      rsp_o
);

  import ils_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GET   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [LenW-1:0]         len_q, len_d;
  logic                    done_q, done_d;
  logic                    pend_q, pend_d;
  ils_rsp_t                rsp_q, rsp_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic [AddrW-1:0]        wa_q, wa_d;
  logic [AddrW-1:0]        ip_q, ip_d;
  logic [LenW-1:0]         cnt_q, cnt_d;
  logic                    up_q, up_d;
  logic signed [VAL_W-1:0] val_q, val_d;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] mem_rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_wdata;

  // request decode
  logic             accept;
  logic             pos_neg;
  logic [POS_W-1:0] pos_u;
  logic [POS_W-1:0] len_ext;
  logic             pos_in_list;
  logic             pos_past_len;
  logic             full;
  logic [AddrW-1:0] pos_a;
  logic [AddrW-1:0] len_a;
  logic [AddrW-1:0] step;

  assign accept       = start && (state_q == S_IDLE);
  assign pos_neg      = req_i.position[POS_W-1];
  assign pos_u        = req_i.position;
  assign len_ext      = POS_W'(len_q);
  assign pos_in_list  = !pos_neg && (pos_u < len_ext);
  assign pos_past_len = !pos_neg && (pos_u > len_ext);
  assign full         = (len_q == LenW'(CAPACITY));
  assign pos_a        = req_i.position[AddrW-1:0];
  assign len_a        = len_q[AddrW-1:0];

  // shared index stepper: down for insert, up for delete
  assign step = up_q ? {AddrW{1'b1}} : AddrW'(1);

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    done_d    = 1'b0;
    pend_d    = 1'b0;
    rsp_d     = rsp_q;
    idx_d     = idx_q;
    wa_d      = wa_q;
    ip_d      = ip_q;
    cnt_d     = cnt_q;
    up_d      = up_q;
    val_d     = val_q;
    mem_we    = 1'b0;
    mem_waddr = wa_q;
    mem_wdata = mem_rdata_q;
    mem_raddr = idx_q;

    case (state_q)
      S_IDLE: begin
        mem_raddr = pos_a;
        if (accept) begin
          val_d = req_i.value_in;
          rsp_d.value_out = '0;
          rsp_d.status    = ST_OK;
          case (req_i.cmd)
            CMD_GET: begin
              if (pos_in_list) begin
                state_d = S_GET;
              end else begin
                rsp_d.value_out = VAL_NOT_FOUND;
                rsp_d.status    = ST_INVALID;
                done_d          = 1'b1;
              end
            end
            CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_ADD_IDX: begin
              // insertion point, then the beyond-length and full checks
              if (req_i.cmd == CMD_ADD_HEAD) begin
                ip_d = '0;
              end else if (req_i.cmd == CMD_ADD_TAIL) begin
                ip_d = len_a;
              end else if (pos_neg || pos_u == '0) begin
                ip_d = '0;
              end else begin
                ip_d = pos_a;
              end
              if (req_i.cmd == CMD_ADD_IDX && pos_past_len) begin
                rsp_d.status = ST_INVALID;
                done_d       = 1'b1;
              end else if (full) begin
                rsp_d.status = ST_FULL;
                done_d       = 1'b1;
              end else begin
                up_d    = 1'b1;
                idx_d   = len_a - AddrW'(1);
                cnt_d   = len_q - LenW'(ip_d);
                state_d = S_SHIFT;
              end
            end
            CMD_DEL_IDX: begin
              if (pos_in_list) begin
                up_d    = 1'b0;
                idx_d   = pos_a + AddrW'(1);
                cnt_d   = len_q - LenW'(pos_a) - LenW'(1);
                state_d = S_SHIFT;
              end else begin
                rsp_d.status = ST_INVALID;
                done_d       = 1'b1;
              end
            end
            default: begin
              rsp_d.status = ST_INVALID;
              done_d       = 1'b1;
            end
          endcase
        end
      end

      S_GET: begin
        rsp_d.value_out = mem_rdata_q;
        rsp_d.status    = ST_OK;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      S_SHIFT: begin
        // read one element per cycle, write it one slot over the next cycle
        if (cnt_q != '0) begin
          pend_d = 1'b1;
          wa_d   = idx_q - step;
          idx_d  = idx_q + step;
          cnt_d  = cnt_q - LenW'(1);
        end
        if (pend_q) begin
          mem_we = 1'b1;
        end else if (cnt_q == '0) begin
          // all moves done: place the new value or shrink the list
          if (up_q) begin
            mem_we    = 1'b1;
            mem_waddr = ip_q;
            mem_wdata = val_q;
            len_d     = len_q + LenW'(1);
          end else begin
            len_d = len_q - LenW'(1);
          end
          rsp_d.value_out = '0;
          rsp_d.status    = ST_OK;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // element memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  // payload and sequencer working registers
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    idx_q <= idx_d;
    wa_q  <= wa_d;
    ip_q  <= ip_d;
    cnt_q <= cnt_d;
    up_q  <= up_d;
    val_q <= val_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = done_q;
  assign rsp_o          = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/ils_checker.sv -----
// port-level checker for the indexed list store, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module ils_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_valid_o,
  input wire ils_pkg::ils_rsp_t rsp_o
);

  import ils_pkg::*;

  // a taken request either keeps the block busy or answers right away
  `ILS_ASSERT(a_accept_progress, clk_i, rst_ni, (start && !busy) |=> (busy || result_valid_o))

  // results only appear once the sequencer is back at rest
  `ILS_ASSERT(a_result_not_busy, clk_i, rst_ni, result_valid_o |-> !busy)

  // busy is only entered from a taken request
  `ILS_ASSERT(a_busy_from_request, clk_i, rst_ni, $rose(busy) |-> $past(start))

  // a dropped insert carries a zero value and a defined status code
  `ILS_ASSERT(a_full_zero_value, clk_i, rst_ni,
              (result_valid_o && rsp_o.status == ST_FULL) |-> (rsp_o.value_out == '0))

  // reset leaves the block idle with no result pending
  `ILS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (!busy && !result_valid_o))

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

`default_nettype wire
